### hw/rtl/spn_pkg.sv
package spn_pkg;

    localparam int BlockW = 16;
    localparam int KeyW   = 32;
    localparam int NibW   = 4;
    localparam int Rounds = 4;

    localparam logic [KeyW-1:0] KEY_RESET = 32'h3A94_D63F;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef logic [BlockW-1:0] block_t;

    // one word in flight: operation plus block
    typedef struct packed {
        logic   cmd;
        block_t data;
    } word_t;

    // per-stage round control
    typedef struct packed {
        logic   first;
        logic   last;
        block_t key_enc;
        block_t key_dec;
        block_t post_enc;
        block_t post_dec;
    } round_ctl_t;

    localparam logic [NibW-1:0] SBOX_FWD [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam logic [NibW-1:0] SBOX_INV [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    // source position (MSB-first) of each output bit (MSB-first)
    localparam logic [3:0] PERM_SRC [16] = '{
        4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    function automatic block_t subst_fwd(input block_t x);
        block_t y;
        for (int n = 0; n < BlockW / NibW; n++)
        begin
            y[n*NibW +: NibW] = SBOX_FWD[x[n*NibW +: NibW]];
        end
        return y;
    endfunction

    function automatic block_t subst_inv(input block_t x);
        block_t y;
        for (int n = 0; n < BlockW / NibW; n++)
        begin
            y[n*NibW +: NibW] = SBOX_INV[x[n*NibW +: NibW]];
        end
        return y;
    endfunction

    function automatic block_t transpose(input block_t x);
        block_t y;
        for (int i = 0; i < BlockW; i++)
        begin
            y[BlockW-1-i] = x[BlockW-1-int'(PERM_SRC[i])];
        end
        return y;
    endfunction

    // round key r: key bits 31-4r down to 16-4r
    function automatic block_t round_key(input logic [KeyW-1:0] key, input int r);
        block_t k;
        case (r)
            0:       k = key[31:16];
            1:       k = key[27:12];
            2:       k = key[23:8];
            3:       k = key[19:4];
            default: k = key[15:0];
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/spn_block_cipher_16bit.sv
// Channel   Direction  Signals                              Carries
// s_axis    in         tvalid tready tdata[15:0] tuser[0]   block in, cmd (0 enc, 1 dec)
// m_axis    out        tvalid tready tdata[15:0]            block out
// cfg       in         valid ready data[31:0]               cipher key
//
// One word per cycle sustained while the output is ready; one register stage per round.
// The output stage is the fourth round register, so a stalled result does not
// stop the earlier stages from filling. Each stage's ready is its own emptiness
// or the ready of the stage after it.
// Reset clears all valid bits and loads the key with 32'h3A94D63F.
// Key writes are always accepted (cfg_ready is tied high).
module spn_block_cipher_16bit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] data_in
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] data_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data        // [31:0] cipher_key
);
    import spn_pkg::*;

    logic [KeyW-1:0] key_reg;

    // pipe index 0 is the input port, index Rounds is the output stage
    logic  pipe_valid [Rounds+1];
    logic  pipe_ready [Rounds+1];
    word_t pipe_word  [Rounds+1];
    round_ctl_t ctl   [Rounds];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    assign pipe_valid[0]     = s_axis_tvalid;
    assign s_axis_tready     = pipe_ready[0];
    assign pipe_word[0].cmd  = s_axis_tuser[0];
    assign pipe_word[0].data = s_axis_tdata;

    assign m_axis_tvalid      = pipe_valid[Rounds];
    assign pipe_ready[Rounds] = m_axis_tready;
    assign m_axis_tdata       = pipe_word[Rounds].data;

    for (genvar i = 0; i < Rounds; i++)
    begin : g_round
        // encrypt uses key i, decrypt walks the keys backward from key 4;
        // the final whitening key rides on the last stage
        always_comb
        begin
            ctl[i].first    = (i == 0);
            ctl[i].last     = (i == Rounds - 1);
            ctl[i].key_enc  = round_key(key_reg, i);
            ctl[i].key_dec  = round_key(key_reg, Rounds - i);
            ctl[i].post_enc = (i == Rounds - 1) ? round_key(key_reg, Rounds) : '0;
            ctl[i].post_dec = (i == Rounds - 1) ? round_key(key_reg, 0) : '0;
        end

        spn_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_word   (pipe_word[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_word  (pipe_word[i+1])
        );
    end

`ifndef SYNTH
    // a draining output means the whole pipe can take a word
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // an accepted word lands in the first round register
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> pipe_valid[1])
        else $error("accepted word lost at first stage");

    // a stalled internal stage holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_valid[2] && !pipe_ready[2]) |=> (pipe_valid[2] && $stable(pipe_word[2])))
        else $error("stalled stage word changed");
`endif

endmodule

### hw/rtl/spn_stage.sv
module spn_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  spn_pkg::round_ctl_t ctl,
    input  logic               in_valid,
    output logic               in_ready,
    input  spn_pkg::word_t     in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output spn_pkg::word_t     out_word
);
    import spn_pkg::*;

    logic   valid_reg;
    word_t  word_reg;
    word_t  word_next;
    block_t enc_x;
    block_t enc_s;
    block_t dec_x;
    block_t dec_t;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // enc: S(x ^ k), then P except in the last round, then post key
    // dec: x ^ k, P except in the first round, then S^-1 and post key
    always_comb
    begin
        enc_x = in_word.data ^ ctl.key_enc;
        enc_s = subst_fwd(enc_x);
        if (!ctl.last)
        begin
            enc_s = transpose(enc_s);
        end
        dec_x = in_word.data ^ ctl.key_dec;
        dec_t = ctl.first ? dec_x : transpose(dec_x);
        word_next.cmd = in_word.cmd;
        if (in_word.cmd == CMD_DEC)
        begin
            word_next.data = subst_inv(dec_t) ^ ctl.post_dec;
        end
        else
        begin
            word_next.data = enc_s ^ ctl.post_enc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

### tb/spn_block_cipher_16bit_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, predicts each output word from the key in
// force when its input word was accepted, and compares in order.
module spn_block_cipher_16bit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked
);
    import spn_pkg::*;

    localparam int MaxReports = 20;

    localparam logic [3:0] SUB_ENC [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam logic [3:0] SUB_DEC [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    logic [KeyW-1:0] key_now;
    block_t          expected_blocks [$];
    block_t          want;

    function automatic block_t sub_nibbles(input block_t x, input logic inverse);
        block_t y;
        for (int n = 0; n < 4; n++)
        begin
            y[4*n +: 4] = inverse ? SUB_DEC[x[4*n +: 4]] : SUB_ENC[x[4*n +: 4]];
        end
        return y;
    endfunction

    // 4x4 bit-matrix transpose, MSB-first numbering
    function automatic block_t bit_transpose(input block_t x);
        block_t y;
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                y[15 - (4*a + b)] = x[15 - (4*b + a)];
            end
        end
        return y;
    endfunction

    // window of key bits 31-4r down to 16-4r
    function automatic block_t subkey(input logic [KeyW-1:0] k, input int r);
        return k[KeyW-1-4*r -: BlockW];
    endfunction

    function automatic block_t cipher_block(input logic [KeyW-1:0] k, input logic op,
                                            input block_t d);
        block_t w;
        w = d;
        if (op == CMD_ENC)
        begin
            for (int r = 0; r < Rounds - 1; r++)
            begin
                w = bit_transpose(sub_nibbles(w ^ subkey(k, r), 1'b0));
            end
            w = sub_nibbles(w ^ subkey(k, Rounds - 1), 1'b0) ^ subkey(k, Rounds);
        end
        else
        begin
            w = sub_nibbles(w ^ subkey(k, Rounds), 1'b1);
            for (int r = Rounds - 1; r >= 1; r--)
            begin
                w = sub_nibbles(bit_transpose(w ^ subkey(k, r)), 1'b1);
            end
            w = w ^ subkey(k, 0);
        end
        return w;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
        key_now = KEY_RESET;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_now = KEY_RESET;
            expected_blocks.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("%0t: unexpected word: expected none, actual %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    checked++;
                    if (m_tdata !== want)
                    begin
                        errors++;
                        if (errors <= MaxReports)
                            $display("%0t: data_out mismatch: expected %h, actual %h",
                                     $time, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_blocks.push_back(cipher_block(key_now, s_tuser[0], s_tdata));
            if (cfg_valid && cfg_ready)
                key_now = cfg_data;
        end
        pending = expected_blocks.size();
    end

endmodule

### tb/spn_block_cipher_16bit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 16-bit SPN cipher core. All prediction and
// comparison happens in the checker; this module only drives the channels.
module spn_block_cipher_16bit_tb;

    import spn_pkg::*;

    // generous ceiling for ~1800 words with gaps and stalls
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 250;    // long output stall to back up the pipe
    localparam int SETTLE      = 10;     // > depth of the 4-stage pipe
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 220;

    // receiver stall styles
    localparam int RX_FREE     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_RARE     = 2;
    localparam int RX_PERIODIC = 3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    int errors;
    int pending;
    int checked;

    int cycles      = 0;
    int rx_style    = RX_FREE;
    int hold_req    = 0;   // bumped by stimulus to request one long stall
    int gap_max     = 0;   // sender idle gap ceiling for the current phase
    int burst_left  = 1;
    int words_sent  = 0;
    int dec_sent    = 0;
    int keys_loaded = 0;

    spn_block_cipher_16bit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    spn_block_cipher_16bit_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: its own stall pattern, plus a long hold-off on request.
    // The hold is counted here so the sender keeps pushing meanwhile.
    int rx_tick   = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_RARE:     m_axis_tready <= ($urandom_range(0, 7) != 0);
                RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) >= 3);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Offer one word and wait for the handshake. tvalid stays high across
    // back-to-back words; a burst ends with a random idle gap, which may be zero.
    task automatic send_word(input logic op, input logic [15:0] blk);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= blk;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        if (op == CMD_DEC)
            dec_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Stop offering, let the pipe drain (checker has no words pending),
    // and give the stages time to empty.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic load_key(input logic [31:0] k);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        keys_loaded++;
    endtask

    initial
    begin
        logic        op;
        logic [15:0] blk;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset key, extreme blocks, both operations
        rx_style = RX_FREE;
        gap_max  = 0;
        send_word(CMD_ENC, 16'h0000);
        send_word(CMD_ENC, 16'hFFFF);
        send_word(CMD_DEC, 16'h0000);
        send_word(CMD_DEC, 16'hFFFF);
        send_word(CMD_ENC, 16'h8000);
        send_word(CMD_DEC, 16'h0001);

        // all-zero key: every round key zero
        load_key(32'h0000_0000);
        send_word(CMD_ENC, 16'h0000);
        send_word(CMD_DEC, 16'h0000);
        send_word(CMD_ENC, 16'hFFFF);
        send_word(CMD_DEC, 16'hAAAA);

        // all-one key
        load_key(32'hFFFF_FFFF);
        send_word(CMD_ENC, 16'h0000);
        send_word(CMD_DEC, 16'hFFFF);
        send_word(CMD_ENC, 16'h5555);
        send_word(CMD_DEC, 16'h5555);

        // random phases: new key each, varied idling on both sides
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                load_key(KEY_RESET);
            else
                load_key($urandom);
            rx_style = ph % 4;
            gap_max  = (ph % 3 == 0) ? 0 : ph;
            if (ph == 2)
            begin
                // output held off while the sender pushes with no gaps
                rx_style = RX_FREE;
                gap_max  = 0;
                hold_req++;
            end
            for (int i = 0; i < PER_PHASE; i++)
            begin
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       blk = 16'h0000;
                    1:       blk = 16'hFFFF;
                    default: blk = 16'($urandom);
                endcase
                send_word(op, blk);
            end
        end

        // drain and settle
        wait_idle();

        $display("Sent %0d words (%0d decrypt), checked %0d, across %0d key settings",
                 words_sent, dec_sent, checked, keys_loaded + 1);
        $display("incl. all-zero/all-one keys, bursty input and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/spn_pkg.sv
hw/rtl/spn_stage.sv
hw/rtl/spn_block_cipher_16bit.sv
tb/spn_block_cipher_16bit_checker.sv
tb/spn_block_cipher_16bit_tb.sv
